>>> sv/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// shared types and codes of the delta-list timer queue
// ----------------------------------------------------------------------------
`default_nettype none

package dltq_pkg;

  localparam int DEF_MAX_TIMERS = 16;
  localparam int DEF_ID_BITS    = 8;
  localparam int DEF_TIME_BITS  = 24;

  typedef logic [1:0]  cmd_t;
  typedef logic [2:0]  evt_t;
  typedef logic [7:0]  tid_t;
  typedef logic [23:0] tms_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_TICK   = 2'd2;

  localparam evt_t EV_ADDED     = 3'd0;
  localparam evt_t EV_DUPLICATE = 3'd1;
  localparam evt_t EV_FULL      = 3'd2;
  localparam evt_t EV_FIRED     = 3'd3;
  localparam evt_t EV_REMOVED   = 3'd4;
  localparam evt_t EV_NOT_FOUND = 3'd5;
  localparam evt_t EV_EXPIRED   = 3'd6;

endpackage

`default_nettype wire

>>> sv/dltq_intf.sv
// ----------------------------------------------------------------------------
// dltq request and response channels
// valid/ready channels carrying one command item and one event item
// ----------------------------------------------------------------------------
`default_nettype none

interface dltq_req_if import dltq_pkg::*;;
  logic valid;
  logic ready;
  cmd_t cmd;
  tid_t timer_id;
  tms_t timeout_ms;
  logic periodic;

  modport source (output valid, cmd, timer_id, timeout_ms, periodic, input ready);
  modport sink   (input valid, cmd, timer_id, timeout_ms, periodic, output ready);
endinterface

interface dltq_rsp_if import dltq_pkg::*;;
  logic valid;
  logic ready;
  evt_t event_res;
  tid_t event_timer;
  logic last;

  modport source (output valid, event_res, event_timer, last, input ready);
  modport sink   (input valid, event_res, event_timer, last, output ready);
endinterface

`default_nettype wire

>>> sv/delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// many logical timers on one millisecond countdown, kept as a delta list
// ----------------------------------------------------------------------------
// Takes one command item at a time (add, remove, tick) and answers with event
// items, the final one marked by last. A comparator and adder walk the list
// one entry per cycle for an add or remove, followed by the response handshake.
// A tick that expires nothing, or an unknown command, answers with no item; each
// expired entry is reported in turn, and each periodic one is re-inserted with a
// further walk of the list. The request side is not ready until the item is
// finished.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue_core import dltq_pkg::*; #(
  parameter int MAX_TIMERS = DEF_MAX_TIMERS,
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dltq_req_if.sink    req,
  dltq_rsp_if.source  rsp
);

  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_INS, S_DEL, S_EXPIRE, S_REINS, S_OUT
  } state_t;

  state_t state, ret;

  logic [ID_BITS-1:0]   ent_id [MAX_TIMERS];
  logic [TIME_BITS-1:0] ent_dl [MAX_TIMERS];
  logic [TIME_BITS-1:0] ent_pd [MAX_TIMERS];
  logic                 ent_pr [MAX_TIMERS];
  logic [CW-1:0]        count;

  logic [ID_BITS-1:0]   scan_id [MAX_TIMERS];
  logic [TIME_BITS-1:0] scan_dl [MAX_TIMERS];
  logic [CW-1:0]        k;
  logic [CW-1:0]        pos;
  logic [TIME_BITS-1:0] acc;
  logic [TIME_BITS-1:0] d_at;
  logic [TIME_BITS-1:0] d_nx;
  logic                 found;
  logic                 dup;
  logic                 have_nx;

  logic [ID_BITS-1:0]   stk_id [MAX_TIMERS];
  logic [TIME_BITS-1:0] stk_pd [MAX_TIMERS];
  logic [CW-1:0]        stk_n;

  cmd_t                 cur_cmd;
  logic [ID_BITS-1:0]   cur_id;
  logic [TIME_BITS-1:0] cur_t;
  logic                 cur_per;
  logic                 cur_zero;
  logic                 reins;

  logic                 o_valid;
  evt_t                 o_res;
  tid_t                 o_timer;
  logic                 o_last;

  logic [31:0]          t_wide;
  logic [TIME_BITS-1:0] t_sat;
  logic [15:0]          id_wide;
  logic [ID_BITS-1:0]   id_in;
  logic [15:0]          cur_id_wide;
  logic [15:0]          head_id_wide;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] ins_nx;
  logic [TIME_BITS:0]   rem_sum;
  logic [TIME_BITS-1:0] rem_dl;
  logic [TIME_BITS-1:0] dl1;
  logic [CW-1:0]        pos_nx;

  assign t_wide       = 32'(req.timeout_ms);
  assign t_sat        = (t_wide > 32'(TIME_MAX)) ? TIME_MAX : t_wide[TIME_BITS-1:0];
  assign id_wide      = 16'(req.timer_id);
  assign id_in        = id_wide[ID_BITS-1:0];
  assign cur_id_wide  = 16'(cur_id);
  assign head_id_wide = 16'(ent_id[0]);
  assign diff         = cur_t - acc;
  assign ins_nx       = d_at - diff;
  assign rem_sum      = {1'b0, d_at} + {1'b0, d_nx};
  assign rem_dl       = rem_sum[TIME_BITS] ? TIME_MAX : rem_sum[TIME_BITS-1:0];
  assign pos_nx       = pos + CW'(1);

  generate
    if (MAX_TIMERS > 1) begin : g_nx
      assign dl1 = ent_dl[1];
    end else begin : g_one
      assign dl1 = '0;
    end
  endgenerate

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = o_valid;
  assign rsp.event_res   = o_res;
  assign rsp.event_timer = o_timer;
  assign rsp.last        = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      count   <= '0;
      stk_n   <= '0;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_cmd  <= req.cmd;
            cur_id   <= id_in;
            cur_t    <= (t_sat == '0) ? TIME_BITS'(1) : t_sat;
            cur_zero <= (t_sat == '0);
            cur_per  <= req.periodic;
            reins    <= 1'b0;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          for (int i = 0; i < MAX_TIMERS; i++) begin
            scan_id[i] <= ent_id[i];
            scan_dl[i] <= ent_dl[i];
          end
          k       <= '0;
          acc     <= '0;
          found   <= 1'b0;
          dup     <= 1'b0;
          have_nx <= 1'b0;
          o_timer <= cur_id_wide[7:0];
          o_last  <= 1'b1;
          ret     <= S_IDLE;
          unique case (cur_cmd)
            CMD_ADD: begin
              if (count == CW'(MAX_TIMERS)) begin
                o_res   <= EV_FULL;
                o_valid <= 1'b1;
                state   <= S_OUT;
              end else begin
                state <= S_SCAN;
              end
            end
            CMD_REMOVE: state <= S_SCAN;
            CMD_TICK: begin
              if (count == '0) begin
                state <= S_IDLE;
              end else if (ent_dl[0] > TIME_BITS'(1)) begin
                ent_dl[0] <= ent_dl[0] - TIME_BITS'(1);
                state     <= S_IDLE;
              end else begin
                ent_dl[0] <= '0;
                state     <= S_EXPIRE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end

        S_SCAN: begin
          if (k != count) begin
            for (int i = 0; i < MAX_TIMERS - 1; i++) begin
              scan_id[i] <= scan_id[i+1];
              scan_dl[i] <= scan_dl[i+1];
            end
            k <= k + CW'(1);
            if (cur_cmd == CMD_REMOVE) begin
              if (found && !have_nx) begin
                d_nx    <= scan_dl[0];
                have_nx <= 1'b1;
              end
              if (!found && scan_id[0] == cur_id) begin
                found <= 1'b1;
                pos   <= k;
                d_at  <= scan_dl[0];
              end
            end else begin
              if (scan_id[0] == cur_id) begin
                dup <= 1'b1;
              end
              if (!found) begin
                if (diff < scan_dl[0]) begin
                  found <= 1'b1;
                  pos   <= k;
                  d_at  <= scan_dl[0];
                end else begin
                  acc <= acc + scan_dl[0];
                end
              end
            end
          end else begin
            if (cur_cmd == CMD_REMOVE) begin
              if (!found) begin
                o_res   <= EV_NOT_FOUND;
                o_valid <= 1'b1;
                state   <= S_OUT;
              end else begin
                state <= S_DEL;
              end
            end else begin
              if (!found) begin
                pos <= count;
              end
              if (reins) begin
                state <= S_INS;
              end else if (dup) begin
                o_res   <= EV_DUPLICATE;
                o_valid <= 1'b1;
                state   <= S_OUT;
              end else if (cur_zero && !cur_per) begin
                o_res   <= EV_FIRED;
                o_valid <= 1'b1;
                state   <= S_OUT;
              end else begin
                state <= S_INS;
              end
            end
          end
        end

        S_INS: begin
          for (int i = 1; i < MAX_TIMERS; i++) begin
            if (CW'(i) > pos) begin
              ent_id[i] <= ent_id[i-1];
              ent_pd[i] <= ent_pd[i-1];
              ent_pr[i] <= ent_pr[i-1];
              if (CW'(i) == pos_nx) begin
                ent_dl[i] <= ins_nx;
              end else begin
                ent_dl[i] <= ent_dl[i-1];
              end
            end
          end
          for (int i = 0; i < MAX_TIMERS; i++) begin
            if (CW'(i) == pos) begin
              ent_id[i] <= cur_id;
              ent_dl[i] <= diff;
              ent_pd[i] <= cur_t;
              ent_pr[i] <= cur_per;
            end
          end
          count <= count + CW'(1);
          if (reins) begin
            state <= S_REINS;
          end else begin
            o_res   <= EV_ADDED;
            o_valid <= 1'b1;
            state   <= S_OUT;
          end
        end

        S_DEL: begin
          for (int i = 0; i < MAX_TIMERS - 1; i++) begin
            if (CW'(i) >= pos) begin
              ent_id[i] <= ent_id[i+1];
              ent_pd[i] <= ent_pd[i+1];
              ent_pr[i] <= ent_pr[i+1];
              if (CW'(i) == pos && have_nx) begin
                ent_dl[i] <= rem_dl;
              end else begin
                ent_dl[i] <= ent_dl[i+1];
              end
            end
          end
          count   <= count - CW'(1);
          o_res   <= EV_REMOVED;
          o_valid <= 1'b1;
          state   <= S_OUT;
        end

        S_EXPIRE: begin
          if (count != '0 && ent_dl[0] == '0) begin
            o_res   <= EV_EXPIRED;
            o_timer <= head_id_wide[7:0];
            o_last  <= (count == CW'(1)) || (dl1 != '0);
            o_valid <= 1'b1;
            ret     <= S_EXPIRE;
            state   <= S_OUT;
            if (ent_pr[0]) begin
              for (int i = 1; i < MAX_TIMERS; i++) begin
                stk_id[i] <= stk_id[i-1];
                stk_pd[i] <= stk_pd[i-1];
              end
              stk_id[0] <= ent_id[0];
              stk_pd[0] <= ent_pd[0];
              stk_n     <= stk_n + CW'(1);
            end
            for (int i = 0; i < MAX_TIMERS - 1; i++) begin
              ent_id[i] <= ent_id[i+1];
              ent_dl[i] <= ent_dl[i+1];
              ent_pd[i] <= ent_pd[i+1];
              ent_pr[i] <= ent_pr[i+1];
            end
            count <= count - CW'(1);
          end else begin
            state <= S_REINS;
          end
        end

        S_REINS: begin
          if (stk_n == '0) begin
            state <= S_IDLE;
          end else begin
            cur_cmd <= CMD_ADD;
            cur_id  <= stk_id[0];
            cur_t   <= stk_pd[0];
            cur_per <= 1'b1;
            reins   <= 1'b1;
            for (int i = 0; i < MAX_TIMERS - 1; i++) begin
              stk_id[i] <= stk_id[i+1];
              stk_pd[i] <= stk_pd[i+1];
            end
            stk_n <= stk_n - CW'(1);
            for (int i = 0; i < MAX_TIMERS; i++) begin
              scan_id[i] <= ent_id[i];
              scan_dl[i] <= ent_dl[i];
            end
            k       <= '0;
            acc     <= '0;
            found   <= 1'b0;
            dup     <= 1'b0;
            have_nx <= 1'b0;
            state   <= S_SCAN;
          end
        end

        S_OUT: begin
          if (rsp.ready) begin
            o_valid <= 1'b0;
            state   <= ret;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/dltq_checker.sv
// ----------------------------------------------------------------------------
// dltq_checker
// port-level checks of the timer queue handshakes, bound to the queue core
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response item dropped before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not idle after reset");

  a_busy_on_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while a response item is pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready && !rsp_valid)
    else $error("not busy after taking a request item");

endmodule

bind delta_list_timer_queue_core dltq_checker u_dltq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);

`default_nettype wire

>>> verif/tb_delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// tb_delta_list_timer_queue_core
// self-checking bench for the delta-list timer queue
// ----------------------------------------------------------------------------
// Drives add, remove and tick commands over the request channel, keeps its own
// sorted delta list to predict event items, and checks each response item in
// order. A directed table covers full list, duplicates, zero timeouts, equal
// deadlines, saturation and unknown commands; a random part follows, with
// bursty sending, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_delta_list_timer_queue_core;
  import dltq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = DEF_MAX_TIMERS;
  localparam longint TOP = (64'd1 << DEF_TIME_BITS) - 1;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    evt_t res;
    tid_t tid;
    logic lst;
  } evt_item_t;

  typedef struct {
    cmd_t c;
    tid_t id;
    tms_t t;
    logic p;
    logic chk;
    evt_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dltq_req_if req();
  dltq_rsp_if rsp();

  delta_list_timer_queue_core u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  tid_t   q_id[NT];
  longint q_dl[NT];
  longint q_pd[NT];
  bit     q_per[NT];
  int     q_n;

  evt_item_t pending_events[$];
  int errors = 0;
  int n_evt = 0;
  int n_exp = 0;
  int cycles = 0;
  bit hold_rx = 1'b0;
  bit stim_done = 1'b0;

  function automatic int locate(tid_t id);
    for (int i = 0; i < q_n; i++) if (q_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop(int pos);
    for (int i = pos; i + 1 < q_n; i++) begin
      q_id[i] = q_id[i+1]; q_dl[i] = q_dl[i+1];
      q_pd[i] = q_pd[i+1]; q_per[i] = q_per[i+1];
    end
    if (q_n > 0) q_n--;
  endfunction

  function automatic void place(tid_t id, longint t, bit per);
    longint acc;
    int pos;
    acc = 0;
    for (pos = 0; pos < q_n; pos++) begin
      if (t - acc < q_dl[pos]) break;
      acc += q_dl[pos];
    end
    for (int i = q_n; i > pos; i--) begin
      q_id[i] = q_id[i-1]; q_dl[i] = q_dl[i-1];
      q_pd[i] = q_pd[i-1]; q_per[i] = q_per[i-1];
    end
    q_id[pos] = id; q_dl[pos] = t - acc; q_pd[pos] = t; q_per[pos] = per;
    if (pos < q_n) q_dl[pos+1] -= t - acc;
    q_n++;
  endfunction

  function automatic void add_event(evt_t r, tid_t id);
    evt_item_t e;
    e.res = r; e.tid = id; e.lst = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic int predict_events(cmd_t c, tid_t id, tms_t tm, logic per);
    longint t;
    int p, n0, ne;
    tid_t xid[NT];
    longint xpd[NT];
    bit xper[NT];
    t = tm;
    n0 = pending_events.size();
    ne = 0;
    if (c == CMD_ADD) begin
      if (q_n >= NT) add_event(EV_FULL, id);
      else if (locate(id) >= 0) add_event(EV_DUPLICATE, id);
      else if (t == 0 && !per) add_event(EV_FIRED, id);
      else begin
        place(id, t == 0 ? 1 : t, per);
        add_event(EV_ADDED, id);
      end
    end else if (c == CMD_REMOVE) begin
      p = locate(id);
      if (p < 0) add_event(EV_NOT_FOUND, id);
      else begin
        if (p + 1 < q_n) begin
          q_dl[p+1] += q_dl[p];
          if (q_dl[p+1] > TOP) q_dl[p+1] = TOP;
        end
        drop(p);
        add_event(EV_REMOVED, id);
      end
    end else if (c == CMD_TICK && q_n > 0) begin
      if (q_dl[0] > 0) q_dl[0]--;
      if (q_dl[0] == 0) begin
        do begin
          xid[ne] = q_id[0]; xpd[ne] = q_pd[0]; xper[ne] = q_per[0];
          ne++;
          add_event(EV_EXPIRED, q_id[0]);
          drop(0);
        end while (q_n > 0 && q_dl[0] == 0 && ne < NT);
        for (int k = ne; k > 0; k--)
          if (xper[k-1] && q_n < NT) place(xid[k-1], xpd[k-1] == 0 ? 1 : xpd[k-1], 1'b1);
      end
    end
    if (pending_events.size() > n0) pending_events[$].lst = 1'b1;
    return pending_events.size() - n0;
  endfunction

  task automatic send(cmd_t c, tid_t id, tms_t t, logic p, logic chk, evt_t r);
    int n;
    req.valid <= 1'b1; req.cmd <= c; req.timer_id <= id;
    req.timeout_ms <= t; req.periodic <= p;
    do @(posedge clk); while (!req.ready);
    n = predict_events(c, id, t, p);
    if (chk && n > 0 && pending_events[pending_events.size() - n].res !== r) begin
      errors++;
      if (errors <= 10) $display("table row: expected event %0d, predicted %0d",
                                 r, pending_events[pending_events.size() - n].res);
    end
  endtask

  task automatic idle_req(int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // receiver
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) rsp.ready <= 1'b0;
      else if (cycles % 300 < 100) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // checker
  always @(posedge clk) begin
    evt_item_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      n_evt++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected event %0d id %0d", rsp.event_res,
                                   rsp.event_timer);
      end else begin
        e = pending_events.pop_front();
        if (rsp.event_res == EV_EXPIRED) n_exp++;
        if (rsp.event_res !== e.res || rsp.event_timer !== e.tid || rsp.last !== e.lst) begin
          errors++;
          if (errors <= 10)
            $display("event mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     e.res, e.tid, e.lst, rsp.event_res, rsp.event_timer, rsp.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(cmd_t c, tid_t id, tms_t t, logic p, logic chk, evt_t r);
    row_t w;
    w.c = c; w.id = id; w.t = t; w.p = p; w.chk = chk; w.res = r;
    return w;
  endfunction

  initial begin
    int burst, pick;
    tid_t rid;
    req.valid = 1'b0; req.cmd = CMD_TICK; req.timer_id = '0;
    req.timeout_ms = '0; req.periodic = 1'b0;
    q_n = 0;

    dir_rows.push_back(mk(CMD_TICK,   8'd0,   24'd0,      1'b0, 1'b0, EV_ADDED));
    dir_rows.push_back(mk(CMD_REMOVE, 8'd255, 24'd0,      1'b0, 1'b1, EV_NOT_FOUND));
    dir_rows.push_back(mk(CMD_ADD,    8'd7,   24'd0,      1'b0, 1'b1, EV_FIRED));
    dir_rows.push_back(mk(CMD_ADD,    8'd0,   24'd0,      1'b1, 1'b1, EV_ADDED));
    dir_rows.push_back(mk(CMD_ADD,    8'd255, 24'hFFFFFF, 1'b1, 1'b1, EV_ADDED));
    dir_rows.push_back(mk(CMD_ADD,    8'd255, 24'd5,      1'b0, 1'b1, EV_DUPLICATE));
    dir_rows.push_back(mk(CMD_ADD,    8'd10,  24'd2,      1'b0, 1'b1, EV_ADDED));
    dir_rows.push_back(mk(CMD_ADD,    8'd11,  24'd2,      1'b1, 1'b1, EV_ADDED));
    dir_rows.push_back(mk(2'd3,       8'd10,  24'd2,      1'b1, 1'b0, EV_ADDED));
    dir_rows.push_back(mk(CMD_TICK,   8'd0,   24'd0,      1'b0, 1'b0, EV_ADDED));
    dir_rows.push_back(mk(CMD_TICK,   8'd0,   24'd0,      1'b0, 1'b0, EV_ADDED));
    dir_rows.push_back(mk(CMD_REMOVE, 8'd11,  24'd0,      1'b0, 1'b0, EV_REMOVED));
    dir_rows.push_back(mk(CMD_ADD,    8'd20,  24'hFFFFFE, 1'b0, 1'b0, EV_ADDED));
    dir_rows.push_back(mk(CMD_REMOVE, 8'd255, 24'd0,      1'b0, 1'b1, EV_REMOVED));
    for (int i = 0; i < 13; i++)
      dir_rows.push_back(mk(CMD_ADD, 8'(100 + i), 24'd3, 1'(i & 1), 1'b0, EV_ADDED));
    dir_rows.push_back(mk(CMD_ADD,    8'd200, 24'd4,      1'b0, 1'b1, EV_ADDED));
    dir_rows.push_back(mk(CMD_ADD,    8'd201, 24'd4,      1'b0, 1'b1, EV_FULL));
    dir_rows.push_back(mk(CMD_ADD,    8'd20,  24'd4,      1'b0, 1'b1, EV_FULL));
    for (int i = 0; i < 3; i++)
      dir_rows.push_back(mk(CMD_TICK, 8'd0, 24'd0, 1'b0, 1'b0, EV_ADDED));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send(dir_rows[i].c, dir_rows[i].id, dir_rows[i].t, dir_rows[i].p,
           dir_rows[i].chk, dir_rows[i].res);
      if ($urandom_range(0, 2) == 0) idle_req($urandom_range(1, 4));
    end
    drain();

    // long receiver hold-off while commands keep coming
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send(CMD_ADD, 8'($urandom_range(0, 40)), 24'($urandom_range(0, 6)), 1'($urandom),
             1'b0, EV_ADDED);
    join
    drain();

    for (int n = 0; n < 365; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        pick = $urandom_range(0, 99);
        rid = (q_n > 0 && $urandom_range(0, 1)) ? q_id[$urandom_range(0, q_n - 1)]
                                               : 8'($urandom_range(0, 31));
        if (pick < 5) rid = 8'($urandom);
        if (pick < 35) begin
          if (pick < 3)
            send(CMD_ADD, rid, 24'($urandom), 1'($urandom), 1'b0, EV_ADDED);
          else
            send(CMD_ADD, rid, 24'($urandom_range(0, 12)), 1'($urandom), 1'b0, EV_ADDED);
        end else if (pick < 50) send(CMD_REMOVE, rid, 24'($urandom), 1'($urandom), 1'b0, EV_ADDED);
        else if (pick < 97) send(CMD_TICK, rid, 24'($urandom), 1'($urandom), 1'b0, EV_ADDED);
        else send(2'd3, rid, 24'($urandom), 1'($urandom), 1'b0, EV_ADDED);
      end
      if ($urandom_range(0, 9) == 0) drain();
      else idle_req($urandom_range(0, 6));
    end
    stim_done = 1'b1;
    drain();

    $display("covered %0d event items, %0d expiries, with stalls and hold-off", n_evt, n_exp);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
